@@ src/qcf_pkg.sv @@
// Package: shared types and constants for the quote conflation filter.
`timescale 1ns / 1ps
`default_nettype none
package qcf_pkg;
  localparam int unsigned TABLE_ENTRIES = 1024;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned KEY_W = 104;
  localparam int unsigned CMD_DEPTH = 2;

  localparam logic [7:0] IND_C = 8'h43;
  localparam logic [7:0] IND_G = 8'h47;
  localparam logic [7:0] IND_K = 8'h4B;
  localparam logic [7:0] IND_M = 8'h4D;
  localparam logic [7:0] IND_N = 8'h4E;
  localparam logic [7:0] IND_P = 8'h50;
  localparam logic [7:0] IND_O = 8'h4F;

  // Quote after key formation and indicator decode.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [1:0]       sides;
    logic [31:0]      bid_price;
    logic [31:0]      bid_size;
    logic [31:0]      offer_price;
    logic [31:0]      offer_size;
  } quote_t;

  typedef struct packed {
    logic       publish;
    logic [1:0] sides;
    logic       is_new;
    logic       full;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_WAIT, ST_CMP, ST_DONE
  } back_state_t;
endpackage
`default_nettype wire

@@ src/qcf_front.sv @@
// Front end: form the instrument key, decode the indicator, queue the quote.
`timescale 1ns / 1ps
`default_nettype none
module qcf_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  output logic                 full,
  input  wire logic [39:0]     in_symbol_code,
  input  wire logic [23:0]     in_expiration_code,
  input  wire logic [31:0]     in_strike_value,
  input  wire logic [7:0]      in_participant_code,
  input  wire logic [7:0]      in_appendage_indicator,
  input  wire logic [31:0]     in_bid_price,
  input  wire logic [31:0]     in_bid_size,
  input  wire logic [31:0]     in_offer_price,
  input  wire logic [31:0]     in_offer_size,
  output logic                 q_valid,
  output qcf_pkg::quote_t      q_data,
  input  wire logic            q_take
);
  import qcf_pkg::*;

  quote_t     fifo_r [CMD_DEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  quote_t     qin;
  logic       wr;

  always_comb begin
    qin.key         = {in_symbol_code, in_expiration_code, in_strike_value,
                       in_participant_code};
    qin.bid_price   = in_bid_price;
    qin.bid_size    = in_bid_size;
    qin.offer_price = in_offer_price;
    qin.offer_size  = in_offer_size;
    unique case (in_appendage_indicator) inside
      IND_C, IND_G, IND_K, IND_M, IND_N, IND_P: qin.sides = 2'd1;
      IND_O:                                    qin.sides = 2'd2;
      default:                                  qin.sides = 2'd0;
    endcase
  end

  assign full    = (cnt_r == 2'(CMD_DEPTH));
  assign wr      = push && !full;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = fifo_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      fifo_r[wp_r] <= qin;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) begin
        wp_r <= ~wp_r;
      end
      if (q_take) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(wr) - 2'(q_take);
    end
  end
endmodule
`default_nettype wire

@@ src/qcf_back.sv @@
// Back end: key search, compare and table update, one quote at a time.
`timescale 1ns / 1ps
`default_nettype none
module qcf_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [15:0]     min_size_change,
  input  wire logic            q_valid,
  input  qcf_pkg::quote_t      q_data,
  output logic                 q_take,
  output logic                 res_valid,
  output qcf_pkg::result_t     res_data,
  input  wire logic            res_take
);
  import qcf_pkg::*;

  // Memories: keys and stored quotes, one read and one write port each.
  logic [KEY_W-1:0] key_mem [TABLE_ENTRIES];
  logic [127:0]     quo_mem [TABLE_ENTRIES];

  back_state_t      st_r, st_nxt;
  quote_t           cur_r, cur_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [IDX_W-1:0] raddr;
  logic [KEY_W-1:0] key_rd_r;
  logic [127:0]     quo_rd_r;
  logic             rd_ok_r, rd_ok_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             key_we, quo_we;
  logic [IDX_W-1:0] waddr;
  logic [KEY_W-1:0] key_wd;
  logic [127:0]     quo_wd;
  result_t          res_r, res_nxt;
  logic             rv_r, rv_nxt;
  logic             bid_mv, off_mv;
  logic [31:0]      sb_p, sb_s, so_p, so_s, db, dof;

  assign raddr = ptr_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    key_rd_r <= key_mem[raddr];
    quo_rd_r <= quo_mem[raddr];
    if (key_we) begin
      key_mem[waddr] <= key_wd;
    end
    if (quo_we) begin
      quo_mem[waddr] <= quo_wd;
    end
  end

  assign {sb_p, sb_s, so_p, so_s} = quo_rd_r;
  assign db  = (sb_s > cur_r.bid_size) ? sb_s - cur_r.bid_size : cur_r.bid_size - sb_s;
  assign dof = (so_s > cur_r.offer_size) ? so_s - cur_r.offer_size
                                         : cur_r.offer_size - so_s;
  assign bid_mv = (sb_p != cur_r.bid_price) || (db > {16'd0, min_size_change});
  assign off_mv = (so_p != cur_r.offer_price) || (dof > {16'd0, min_size_change});

  // Take a new quote only once the previous result leaves the result register.
  assign q_take    = (st_r == ST_IDLE) && q_valid && (!rv_r || res_take);
  assign res_valid = rv_r;
  assign res_data  = res_r;

  always_comb begin
    st_nxt     = st_r;
    cur_nxt    = cur_r;
    used_nxt   = used_r;
    ptr_nxt    = ptr_r;
    rd_ok_nxt  = 1'b0;
    rd_idx_nxt = rd_idx_r;
    res_nxt    = res_r;
    rv_nxt     = rv_r && !res_take;
    key_we     = 1'b0;
    quo_we     = 1'b0;
    waddr      = rd_idx_r;
    key_wd     = cur_r.key;
    quo_wd     = {cur_r.bid_price, cur_r.bid_size, cur_r.offer_price, cur_r.offer_size};
    unique case (st_r)
      ST_IDLE: begin
        if (q_take) begin
          cur_nxt = q_data;
          ptr_nxt = '0;
          st_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Issue a read per entry; the compare runs in ST_CMP on the registered read data.
        if (ptr_r < used_r) begin
          rd_ok_nxt  = 1'b1;
          rd_idx_nxt = ptr_r[IDX_W-1:0];
          ptr_nxt    = ptr_r + 1'b1;
          st_nxt     = ST_CMP;
        end else begin
          // Miss: insert at the fill point or flag the table full.
          res_nxt.publish = 1'b1;
          res_nxt.sides   = cur_r.sides;
          res_nxt.is_new  = 1'b1;
          res_nxt.full    = (used_r == CNT_W'(TABLE_ENTRIES));
          if (used_r != CNT_W'(TABLE_ENTRIES)) begin
            waddr    = used_r[IDX_W-1:0];
            key_we   = 1'b1;
            quo_we   = 1'b1;
            used_nxt = used_r + 1'b1;
          end
          st_nxt = ST_DONE;
        end
      end
      ST_CMP: begin
        if (rd_ok_r && key_rd_r == cur_r.key) begin
          res_nxt.is_new = 1'b0;
          res_nxt.full   = 1'b0;
          res_nxt.sides  = cur_r.sides;
          if (min_size_change == 16'd0) begin
            quo_we          = 1'b1;
            res_nxt.publish = 1'b1;
          end else begin
            quo_we = bid_mv || off_mv;
            quo_wd = {bid_mv ? cur_r.bid_price : sb_p, bid_mv ? cur_r.bid_size : sb_s,
                      off_mv ? cur_r.offer_price : so_p,
                      off_mv ? cur_r.offer_size : so_s};
            res_nxt.publish = bid_mv || off_mv || (cur_r.sides != 2'd0);
          end
          st_nxt = ST_DONE;
        end else begin
          st_nxt = ST_SCAN;
        end
      end
      ST_DONE: begin
        // Hold until the result register is free.
        if (!rv_r) begin
          rv_nxt = 1'b1;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    if (st_r == ST_SCAN || st_r == ST_CMP) begin
      res_nxt.publish = res_nxt.publish || (st_nxt == ST_DONE && cur_r.sides != 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    res_r    <= res_nxt;
    rd_idx_r <= rd_idx_nxt;
    ptr_r    <= ptr_nxt;
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      used_r  <= '0;
      rv_r    <= 1'b0;
      rd_ok_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      used_r  <= used_nxt;
      rv_r    <= rv_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
  end
endmodule
`default_nettype wire

@@ src/qcf_out_fifo.sv @@
// Result queue: holds results until the consumer pops them.
`timescale 1ns / 1ps
`default_nettype none
module qcf_out_fifo (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         res_valid,
  input  qcf_pkg::result_t  res_data,
  output logic              res_take,
  input  wire logic         pop,
  output logic              empty,
  output qcf_pkg::result_t  head
);
  import qcf_pkg::*;

  result_t    buf_r [CMD_DEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       rd;

  assign res_take = res_valid && (cnt_r != 2'(CMD_DEPTH));
  assign empty    = (cnt_r == 2'd0);
  assign rd       = pop && !empty;
  assign head     = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (res_take) begin
      buf_r[wp_r] <= res_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (res_take) begin
        wp_r <= ~wp_r;
      end
      if (rd) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(res_take) - 2'(rd);
    end
  end
endmodule
`default_nettype wire

@@ src/quote_conflation_filter.sv @@
// Top level of the quote conflation filter.
`timescale 1ns / 1ps
`default_nettype none
// Quote conflation filter. Push one decoded option quote per transaction;
// one result per quote comes out in order on the result queue (publish,
// best-quote side count, new-instrument and table-full flags). The front
// end forms the 104-bit instrument key and decodes the appendage indicator
// into a two-entry queue; the back end searches the key table linearly, one
// entry per pass through ST_SCAN and ST_CMP, through a single registered
// read port, then inserts the quote on a miss or updates the stored quote
// on a hit. The table holds 1024 instruments filled in arrival order. Reset
// clears the fill count only, so no clearing pass is needed. Write
// min_size_change only when the block is idle: a zero value publishes every
// quote of a known instrument.
module quote_conflation_filter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [39:0] in_symbol_code,
  input  wire logic [23:0] in_expiration_code,
  input  wire logic [31:0] in_strike_value,
  input  wire logic [7:0]  in_participant_code,
  input  wire logic [7:0]  in_appendage_indicator,
  input  wire logic [31:0] in_bid_price,
  input  wire logic [31:0] in_bid_size,
  input  wire logic [31:0] in_offer_price,
  input  wire logic [31:0] in_offer_size,
  output logic             empty,
  input  wire logic        pop,
  output logic             out_publish,
  output logic [1:0]       out_best_quote_sides,
  output logic             out_new_instrument,
  output logic             out_table_full,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_min_size_change
);
  import qcf_pkg::*;

  logic        q_valid, q_take, res_valid, res_take;
  quote_t      q_data;
  result_t     res_data, head;
  logic [15:0] min_size_r;

  // Threshold register; always ready. The host must write only when idle; the block does not enforce this.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_size_r <= 16'd0;
    end else if (cfg_valid) begin
      min_size_r <= cfg_min_size_change;
    end
  end

  qcf_front u_front (
    .clk, .rst_n, .push, .full,
    .in_symbol_code, .in_expiration_code, .in_strike_value, .in_participant_code,
    .in_appendage_indicator, .in_bid_price, .in_bid_size, .in_offer_price,
    .in_offer_size, .q_valid, .q_data, .q_take
  );

  qcf_back u_back (
    .clk, .rst_n, .min_size_change(min_size_r), .q_valid, .q_data, .q_take,
    .res_valid, .res_data, .res_take
  );

  qcf_out_fifo u_out (
    .clk, .rst_n, .res_valid, .res_data, .res_take, .pop, .empty, .head
  );

  assign out_publish          = head.publish;
  assign out_best_quote_sides = head.sides;
  assign out_new_instrument   = head.is_new;
  assign out_table_full       = head.full;
endmodule
`default_nettype wire

@@ bench/qcf_checker.sv @@
// Checker for the quote conflation filter: predicts each result and compares.
`timescale 1ns / 1ps
module qcf_checker
  import qcf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [39:0] in_symbol_code,
  input  logic [23:0] in_expiration_code,
  input  logic [31:0] in_strike_value,
  input  logic [7:0]  in_participant_code,
  input  logic [7:0]  in_appendage_indicator,
  input  logic [31:0] in_bid_price,
  input  logic [31:0] in_bid_size,
  input  logic [31:0] in_offer_price,
  input  logic [31:0] in_offer_size,
  input  logic        empty,
  input  logic        pop,
  input  logic        out_publish,
  input  logic [1:0]  out_best_quote_sides,
  input  logic        out_new_instrument,
  input  logic        out_table_full,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_min_size_change,
  output int          fail_count,
  output int          pending
);
  logic [KEY_W-1:0] inst_key   [TABLE_ENTRIES];
  logic             inst_valid [TABLE_ENTRIES];
  logic [31:0]      last_bid_px [TABLE_ENTRIES];
  logic [31:0]      last_bid_sz [TABLE_ENTRIES];
  logic [31:0]      last_ofr_px [TABLE_ENTRIES];
  logic [31:0]      last_ofr_sz [TABLE_ENTRIES];
  int unsigned      inst_count;
  logic [15:0]      size_thresh;
  result_t          expected_results[$];

  function automatic logic side_changed(logic [31:0] old_px, logic [31:0] old_sz,
                                        logic [31:0] new_px, logic [31:0] new_sz);
    logic [31:0] size_gap;
    size_gap = (old_sz > new_sz) ? old_sz - new_sz : new_sz - old_sz;
    return (old_px != new_px) || (size_gap > {16'd0, size_thresh});
  endfunction

  // Predict one quote and update the instrument table.
  function automatic result_t conflate_quote();
    result_t          r;
    logic [KEY_W-1:0] k;
    int               hit;
    k = {in_symbol_code, in_expiration_code, in_strike_value, in_participant_code};
    hit = -1;
    r = '0;
    for (int i = 0; i < inst_count; i++) begin
      if (inst_valid[i] && inst_key[i] == k) begin
        hit = i;
        break;
      end
    end
    if (hit >= 0) begin
      if (size_thresh == 0) begin
        last_bid_px[hit] = in_bid_price;
        last_bid_sz[hit] = in_bid_size;
        last_ofr_px[hit] = in_offer_price;
        last_ofr_sz[hit] = in_offer_size;
        r.publish = 1'b1;
      end else begin
        if (side_changed(last_bid_px[hit], last_bid_sz[hit], in_bid_price, in_bid_size)) begin
          last_bid_px[hit] = in_bid_price;
          last_bid_sz[hit] = in_bid_size;
          r.publish = 1'b1;
        end
        if (side_changed(last_ofr_px[hit], last_ofr_sz[hit], in_offer_price,
                         in_offer_size)) begin
          last_ofr_px[hit] = in_offer_price;
          last_ofr_sz[hit] = in_offer_size;
          r.publish = 1'b1;
        end
      end
    end else begin
      r.publish = 1'b1;
      r.is_new = 1'b1;
      if (inst_count < TABLE_ENTRIES) begin
        inst_key[inst_count] = k;
        inst_valid[inst_count] = 1'b1;
        last_bid_px[inst_count] = in_bid_price;
        last_bid_sz[inst_count] = in_bid_size;
        last_ofr_px[inst_count] = in_offer_price;
        last_ofr_sz[inst_count] = in_offer_size;
        inst_count++;
      end else begin
        r.full = 1'b1;
      end
    end
    case (in_appendage_indicator) inside
      IND_C, IND_G, IND_K, IND_M, IND_N, IND_P: begin
        r.sides = 2'd1;
        r.publish = 1'b1;
      end
      IND_O: begin
        r.sides = 2'd2;
        r.publish = 1'b1;
      end
      default: r.sides = 2'd0;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst_n) begin
      inst_count = 0;
      size_thresh = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) inst_valid[i] = 1'b0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) size_thresh = cfg_min_size_change;
      if (push && !full) expected_results.push_back(conflate_quote());
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transaction publish=%0b sides=%0d new=%0b full=%0b",
                   $time, out_publish, out_best_quote_sides, out_new_instrument,
                   out_table_full);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.publish !== out_publish || exp_r.sides !== out_best_quote_sides ||
              exp_r.is_new !== out_new_instrument || exp_r.full !== out_table_full) begin
            $display("%0t: mismatch expected publish=%0b sides=%0d new=%0b full=%0b",
                     $time, exp_r.publish, exp_r.sides, exp_r.is_new, exp_r.full);
            $display("%0t:          actual   publish=%0b sides=%0d new=%0b full=%0b",
                     $time, out_publish, out_best_quote_sides, out_new_instrument,
                     out_table_full);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending = expected_results.size();
  end
endmodule

@@ bench/tb_quote_conflation_filter.sv @@
// Testbench top: stimulus, idling and verdict for the quote conflation filter.
`timescale 1ns / 1ps
module tb_quote_conflation_filter;
  import qcf_pkg::*;

  localparam int POOL_KEYS = 40;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [39:0] sym;
    logic [23:0] exp_code;
    logic [31:0] strike;
    logic [7:0]  part;
    logic [7:0]  ind;
    logic [31:0] bid_px;
    logic [31:0] bid_sz;
    logic [31:0] ofr_px;
    logic [31:0] ofr_sz;
  } quote_item_t;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [39:0] in_symbol_code;
  logic [23:0] in_expiration_code;
  logic [31:0] in_strike_value;
  logic [7:0]  in_participant_code;
  logic [7:0]  in_appendage_indicator;
  logic [31:0] in_bid_price;
  logic [31:0] in_bid_size;
  logic [31:0] in_offer_price;
  logic [31:0] in_offer_size;
  logic        empty;
  logic        pop;
  logic        out_publish;
  logic [1:0]  out_best_quote_sides;
  logic        out_new_instrument;
  logic        out_table_full;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_min_size_change;
  int          fail_count;
  int          pending;

  // Stimulus shaping state: keys that get reused, and the last quote sent per key.
  quote_item_t pool[POOL_KEYS];
  logic [15:0] cur_thresh;
  bit          long_hold_req;
  int          idle_cycles;

  quote_conflation_filter i_dut (.*);

  qcf_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: count cycles with no transaction on any channel.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_quote_conflation_filter: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random pop stalls, mostly short, a few long, plus one long hold-off.
  initial begin
    int stall;
    stall = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = 400;
      end
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4: stall = $urandom_range(1, 3);
          5:             stall = $urandom_range(10, 40);
          default:       stall = 0;
        endcase
      end
    end
  end

  // Offer one quote and hold it until the filter accepts it; push stays high after.
  task automatic send_quote(input quote_item_t q);
    push <= 1'b1;
    in_symbol_code <= q.sym;
    in_expiration_code <= q.exp_code;
    in_strike_value <= q.strike;
    in_participant_code <= q.part;
    in_appendage_indicator <= q.ind;
    in_bid_price <= q.bid_px;
    in_bid_size <= q.bid_sz;
    in_offer_price <= q.ofr_px;
    in_offer_size <= q.ofr_sz;
    forever begin
      @(negedge clk);
      if (!full) break;
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  // Sometimes drop push for a random gap, usually short, now and then long.
  task automatic sender_gap();
    int g;
    case ($urandom_range(0, 19))
      0, 1, 2, 3: g = $urandom_range(1, 3);
      4:          g = $urandom_range(15, 60);
      default:    g = 0;
    endcase
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Wait until every expected result has come, then write the threshold.
  task automatic set_threshold(input logic [15:0] v);
    push <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_min_size_change <= v;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
      @(posedge clk);
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
    cur_thresh = v;
  endtask

  function automatic logic [7:0] pick_indicator();
    logic [7:0] codes[7];
    codes = '{IND_C, IND_G, IND_K, IND_M, IND_N, IND_P, IND_O};
    if ($urandom_range(0, 9) < 3) return codes[$urandom_range(0, 6)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Move a size around the threshold so both sides of the boundary are hit.
  function automatic logic [31:0] nudge_size(input logic [31:0] s);
    case ($urandom_range(0, 6))
      0:       return s;
      1:       return s + cur_thresh;
      2:       return s - cur_thresh;
      3:       return s + cur_thresh + 1;
      4:       return s - cur_thresh - 1;
      5:       return s + 32'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  function automatic quote_item_t random_key_quote();
    quote_item_t q;
    q.sym = {8'($urandom), 32'($urandom)};
    q.exp_code = 24'($urandom);
    q.strike = $urandom;
    q.part = 8'($urandom);
    q.ind = pick_indicator();
    q.bid_px = $urandom;
    q.bid_sz = $urandom;
    q.ofr_px = $urandom;
    q.ofr_sz = $urandom;
    return q;
  endfunction

  // Mostly known instruments with prices held or moved and sizes near the threshold.
  task automatic send_random_quote();
    quote_item_t q;
    int          k;
    if ($urandom_range(0, 19) == 0) begin
      q = random_key_quote();
    end else begin
      k = $urandom_range(0, POOL_KEYS - 1);
      q = pool[k];
      q.ind = pick_indicator();
      if ($urandom_range(0, 3) == 0) q.bid_px = $urandom;
      if ($urandom_range(0, 3) == 0) q.ofr_px = $urandom;
      q.bid_sz = nudge_size(q.bid_sz);
      q.ofr_sz = nudge_size(q.ofr_sz);
      pool[k] = q;
    end
    send_quote(q);
    sender_gap();
  endtask

  initial begin
    quote_item_t q;
    logic [7:0]  codes[9];
    long_hold_req = 1'b0;
    cur_thresh = '0;
    rst_n <= 1'b0;
    push <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_min_size_change <= '0;
    in_symbol_code <= '0;
    in_expiration_code <= '0;
    in_strike_value <= '0;
    in_participant_code <= '0;
    in_appendage_indicator <= '0;
    in_bid_price <= '0;
    in_bid_size <= '0;
    in_offer_price <= '0;
    in_offer_size <= '0;
    for (int i = 0; i < POOL_KEYS; i++) pool[i] = random_key_quote();
    pool[0] = '{default: '0};
    pool[1] = '{40'hFF_FFFF_FFFF, 24'hFF_FFFF, '1, '1, '1, '1, '1, '1, '1};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme keys and values, every indicator, unknown bytes.
    send_quote(pool[0]);
    send_quote(pool[1]);
    codes = '{IND_C, IND_G, IND_K, IND_M, IND_N, IND_P, IND_O, 8'h00, 8'hFF};
    foreach (codes[i]) begin
      q = pool[i % 2];
      q.ind = codes[i];
      q.bid_px = i[0] ? '1 : '0;
      send_quote(q);
    end

    // Directed: size boundary at the largest threshold, in both directions.
    set_threshold(16'hFFFF);
    q = pool[0];
    q.ind = 8'h00;
    q.bid_px = '0;
    q.bid_sz = 32'd0;
    send_quote(q);
    q.bid_sz = 32'd65535;
    send_quote(q);
    q.bid_sz = 32'd65536;
    send_quote(q);
    q.bid_sz = 32'hFFFF_FFFF;
    send_quote(q);
    q.bid_sz = 32'd0;
    send_quote(q);
    q.ofr_sz = 32'hFFFF_0000;
    send_quote(q);
    q.ofr_px = 32'h1;
    send_quote(q);
    q.ind = IND_O;
    send_quote(q);
    pool[0] = q;

    // Random phases over several thresholds.
    set_threshold(16'd1);
    repeat (90) send_random_quote();
    set_threshold(16'd300);
    long_hold_req = 1'b1;
    repeat (90) send_random_quote();
    set_threshold(16'($urandom));
    repeat (45) send_random_quote();
    push <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);
    repeat (45) send_random_quote();
    set_threshold(16'hFFFF);
    repeat (90) send_random_quote();
    set_threshold(16'd0);
    repeat (90) send_random_quote();

    // Close with a mix of fresh and known instruments.
    for (int n = 0; n < 8; n++) begin
      if (n[0]) begin
        q = random_key_quote();
        q.sym = {8'h5A, 32'(n)};
      end else begin
        q = pool[n / 2 % 2];
        q.ind = pick_indicator();
      end
      send_quote(q);
    end
    push <= 1'b0;
    @(posedge clk);

    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_quote_conflation_filter: PASS");
    end else begin
      $display("tb_quote_conflation_filter: FAIL");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
src/qcf_pkg.sv
src/qcf_front.sv
src/qcf_back.sv
src/qcf_out_fifo.sv
src/quote_conflation_filter.sv
bench/qcf_checker.sv
bench/tb_quote_conflation_filter.sv
